>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hw/rtl/swma_pkg.sv
// Shared constants, codes and helpers for the stack with middle access.
// No dependencies.
`default_nettype none
package swma_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELMID = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Cell index of the middle element; count must be nonzero.
  function automatic addr_t middle_addr(input count_t cnt);
    count_t top;
    top = cnt - count_t'(1);
    return addr_t'(top - (top >> 1));
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/stack_with_middle_access.sv
// Bounded stack of signed words with middle read and middle delete.
// Depends on swma_pkg and assert_macros.svh.
//
// Usage: drive opcode_i and push_value_i with start_i; the command is taken
// at a rising edge where start_i is high and busy_o is low. Each command
// gives exactly one result, shown for one cycle with result_valid_o high:
// middle_value_o (middle after the command, 0 when empty), element_count_o
// and status_o (ok, empty, full). The receiver cannot stall the block.
// After the accepting edge, push, pop, unused opcode and refused commands
// pass through S_READ (middle read) and then S_RESP (result).
// A delete of the middle first moves every word above the middle down one cell
// in S_SHIFT through the stack memory (one read and one write port), one word
// per cycle, then goes through S_READ and S_RESP; it moves k = count - 1 - middle
// index words (at most StackDepth/2 - 1). busy_o stays high until the result
// cycle ends; the next command is accepted the cycle after. Reset clears the
// count and the control state; the stack memory is not cleared, since an
// unwritten cell never reaches middle_value_o.
`default_nettype none
`include "assert_macros.svh"
module stack_with_middle_access
  import swma_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      middle_value_o,
  output logic [6:0]              element_count_o,
  output logic [1:0]              status_o
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_READ  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  count_t  cnt_q, cnt_d;
  addr_t   ptr_q, ptr_d;
  status_e status_q, status_d;
  logic    mv_valid_q, mv_valid_d;
  addr_t   mv_addr_q, mv_addr_d;

  logic [31:0] mem [StackDepth];
  logic [31:0] rdata_q;
  logic        accept;
  logic        wr_en;
  addr_t       wr_addr;
  logic [31:0] wr_data;
  logic        rd_en;
  addr_t       rd_addr;
  logic [CountW:0] ptr_plus1, ptr_plus2;

  assign accept    = start_i && (state_q == S_IDLE);
  assign ptr_plus1 = (CountW+1)'(ptr_q) + (CountW+1)'(1);
  assign ptr_plus2 = (CountW+1)'(ptr_q) + (CountW+1)'(2);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    status_d   = status_q;
    mv_valid_d = 1'b0;
    mv_addr_d  = mv_addr_q;
    wr_en      = 1'b0;
    wr_addr    = mv_addr_q;
    wr_data    = rdata_q;
    rd_en      = 1'b0;
    rd_addr    = addr_t'(ptr_plus1);

    // Pending move from the gap-closing pass lands in the cycle after its read.
    if (mv_valid_q) begin
      wr_en = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_READ;
          case (opcode_i)
            OP_PUSH: begin
              if (cnt_q >= count_t'(StackDepth)) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = addr_t'(cnt_q);
                wr_data = push_value_i;
                cnt_d   = cnt_q + count_t'(1);
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - count_t'(1);
              end
            end
            OP_DELMID: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                ptr_d = middle_addr(cnt_q);
                if ((CountW+1)'(middle_addr(cnt_q)) + (CountW+1)'(1)
                    < (CountW+1)'(cnt_q)) begin
                  state_d = S_SHIFT;
                end else begin
                  cnt_d = cnt_q - count_t'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // Read the word above, write it one cell down next cycle.
        rd_en      = 1'b1;
        rd_addr    = addr_t'(ptr_plus1);
        mv_valid_d = 1'b1;
        mv_addr_d  = ptr_q;
        ptr_d      = addr_t'(ptr_plus1);
        if (ptr_plus2 >= (CountW+1)'(cnt_q)) begin
          cnt_d   = cnt_q - count_t'(1);
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = middle_addr(cnt_q);
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // Forward a move that is written in the same cycle.
      if (wr_en && wr_addr == rd_addr) begin
        rdata_q <= wr_data;
      end else begin
        rdata_q <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      ptr_q      <= '0;
      status_q   <= ST_OK;
      mv_valid_q <= 1'b0;
      mv_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      status_q   <= status_d;
      mv_valid_q <= mv_valid_d;
      mv_addr_q  <= mv_addr_d;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_valid_o  = (state_q == S_RESP);
  assign middle_value_o  = (cnt_q == '0) ? 32'sd0 : $signed(rdata_q);
  assign element_count_o = 7'(cnt_q);
  assign status_o        = status_q;

  `ASSERT_NEVER(a_cnt_bound, cnt_q > count_t'(StackDepth), "count above depth")
  `ASSERT_PROP(a_accept_busy, start_i && !busy_o |=> busy_o, "accepted item not busy")
  `ASSERT_PROP(a_resp_idle, result_valid_o |=> !busy_o && !result_valid_o,
               "result not followed by idle")
  `ASSERT_PROP(a_full_cnt, result_valid_o && status_o == ST_FULL |-> cnt_q == count_t'(StackDepth),
               "full status with room left")
endmodule
`default_nettype wire

>>> bench/tb_stack_with_middle_access.sv
// Self-checking bench for stack_with_middle_access: directed and random push/pop/delete-middle/nop items
// checked against a behavioral stack model. Depends on swma_pkg and the RTL.
`default_nettype none
module tb_stack_with_middle_access;
  import swma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] mid;
    logic [6:0]  cnt;
    logic [1:0]  st;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  opcode_i = '0;
  logic signed [31:0] push_value_i = '0;
  logic        busy_o, result_valid_o;
  logic signed [31:0] middle_value_o;
  logic [6:0]  element_count_o;
  logic [1:0]  status_o;

  stack_with_middle_access i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .push_value_i,
    .result_valid_o, .middle_value_o, .element_count_o, .status_o
  );

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];
  logic [31:0] cells[StackDepth];
  int unsigned depth_now = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  bit hold_for_drain = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned mid_cell(int unsigned n);
    return (n - 1) - (n - 1) / 2;
  endfunction

  // Apply one command to the model stack and queue the reply it yields.
  function automatic void predict_reply(cmd_t c);
    reply_t r;
    r.st = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (depth_now >= StackDepth) r.st = ST_FULL;
        else begin
          cells[depth_now] = c.word;
          depth_now++;
        end
      end
      OP_POP: begin
        if (depth_now == 0) r.st = ST_EMPTY;
        else depth_now--;
      end
      OP_DELMID: begin
        if (depth_now == 0) r.st = ST_EMPTY;
        else begin
          for (int unsigned i = mid_cell(depth_now); i + 1 < depth_now; i++)
            cells[i] = cells[i + 1];
          depth_now--;
        end
      end
      default: ;
    endcase
    r.mid = (depth_now == 0) ? 32'd0 : cells[mid_cell(depth_now)];
    r.cnt = depth_now[6:0];
    expected_replies.push_back(r);
  endfunction

  function automatic cmd_t mk(logic [1:0] op, logic [31:0] w);
    cmd_t c;
    c.op = op;
    c.word = w;
    return c;
  endfunction

  // Driver: bursts and gaps; a drain request stalls until every reply is in.
  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_reply(mk(opcode_i, push_value_i));
        void'(pending_cmds.pop_front());
      end
      if (start_i && busy_o) begin
        // hold the item until it is taken
      end else if (hold_for_drain && expected_replies.size() != 0
                   && !(start_i && !busy_o)) begin
        start_i <= 1'b0;
      end else if (pending_cmds.size() == 0
                   || (start_i && !busy_o && pending_cmds.size() == 0)) begin
        start_i <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else begin
        c = pending_cmds[0];
        if (start_i && !busy_o && hold_for_drain) begin
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          opcode_i <= c.op;
          push_value_i <= c.word;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expected reply.
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply: mid=%0d cnt=%0d st=%0d",
                                       middle_value_o, element_count_o, status_o);
      end else begin
        e = expected_replies.pop_front();
        if (e.mid !== middle_value_o || e.cnt !== element_count_o
            || e.st !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: exp mid=%0d cnt=%0d st=%0d got mid=%0d cnt=%0d st=%0d",
                     $signed(e.mid), e.cnt, e.st, middle_value_o, element_count_o,
                     status_o);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_replies.size() != 0 || start_i)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned roll;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty removals, extremes, odd op code, fill to full, drain.
    pending_cmds.push_back(mk(OP_POP, 32'd0));
    pending_cmds.push_back(mk(OP_DELMID, 32'd0));
    pending_cmds.push_back(mk(OP_NOP, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(OP_PUSH, 32'h8000_0000));
    pending_cmds.push_back(mk(OP_PUSH, 32'h7FFF_FFFF));
    pending_cmds.push_back(mk(OP_PUSH, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk(OP_DELMID, 32'd0));
    pending_cmds.push_back(mk(OP_NOP, 32'd0));
    pending_cmds.push_back(mk(OP_POP, 32'd0));
    pending_cmds.push_back(mk(OP_POP, 32'd0));
    pending_cmds.push_back(mk(OP_PUSH, 32'd0));
    pending_cmds.push_back(mk(OP_DELMID, 32'd0));
    hold_for_drain = 1'b1;
    wait_drained();
    hold_for_drain = 1'b0;

    for (int i = 0; i < StackDepth + 2; i++) pending_cmds.push_back(mk(OP_PUSH, rand_word()));
    pending_cmds.push_back(mk(OP_DELMID, 32'd0));
    pending_cmds.push_back(mk(OP_PUSH, 32'h5555_AAAA));
    pending_cmds.push_back(mk(OP_PUSH, 32'hAAAA_5555));
    for (int i = 0; i < 40; i++) pending_cmds.push_back(mk(OP_DELMID, 32'd0));
    for (int i = 0; i < 30; i++) pending_cmds.push_back(mk(OP_POP, 32'd0));

    // Random: drift the fill level by phases so both full and empty recur.
    for (int i = 0; i < 800; i++) begin
      if (i % 150 < 60) roll = $urandom_range(0, 9) < 7 ? 0 : 1;
      else if (i % 150 < 110) roll = $urandom_range(0, 9) < 3 ? 0 : 1;
      else roll = 2;
      case (roll)
        0: pending_cmds.push_back(mk(OP_PUSH, rand_word()));
        default: begin
          case ($urandom_range(0, 19))
            0: pending_cmds.push_back(mk(OP_NOP, rand_word()));
            1, 2, 3, 4, 5, 6, 7, 8: pending_cmds.push_back(mk(OP_POP, rand_word()));
            default: pending_cmds.push_back(mk(OP_DELMID, rand_word()));
          endcase
          if (roll == 2 && $urandom_range(0, 1) == 0)
            pending_cmds.push_back(mk(OP_PUSH, rand_word()));
        end
      endcase
    end
    wait_drained();
    repeat (StackDepth + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hw/rtl
hw/rtl/swma_pkg.sv
hw/rtl/stack_with_middle_access.sv
bench/tb_stack_with_middle_access.sv
